/* rtl/core/sifb_pkg.sv */
// Shared types and constants for the stuffed information frame builder.
`default_nettype none

package sifb_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned REG_COUNT   = 7;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_FLAG     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ESC      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FLAG_SUB = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ESC_SUB  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDR     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CTL0     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CTL1     = 3'd6;

   localparam logic [BYTE_W-1:0] FLAG_RESET     = 8'd126;
   localparam logic [BYTE_W-1:0] ESC_RESET      = 8'd125;
   localparam logic [BYTE_W-1:0] FLAG_SUB_RESET = 8'd94;
   localparam logic [BYTE_W-1:0] ESC_SUB_RESET  = 8'd93;
   localparam logic [BYTE_W-1:0] ADDR_RESET     = 8'd3;
   localparam logic [BYTE_W-1:0] CTL0_RESET     = 8'd0;
   localparam logic [BYTE_W-1:0] CTL1_RESET     = 8'd64;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic              has_payload;
      logic              frame_start;
      logic              frame_end;
      logic              seq_bit;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              out_last;
   } rsp_type;

   // Classified item handed from the front to the back.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] check;
      logic              has_payload;
      logic              frame_start;
      logic              frame_end;
      logic              seq_bit;
   } job_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag;
      logic [BYTE_W-1:0] esc;
      logic [BYTE_W-1:0] flag_sub;
      logic [BYTE_W-1:0] esc_sub;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] ctl0;
      logic [BYTE_W-1:0] ctl1;
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FLAG,
      ST_ADDR,
      ST_CTL,
      ST_HCHK,
      ST_DATA,
      ST_DATA_SUB,
      ST_CHK,
      ST_CHK_SUB,
      ST_CLOSE
   } step_type;

endpackage

`default_nettype wire

/* rtl/core/stuffed_info_frame_builder.sv */
// Top level of the stuffed information frame builder.
//
//   Channel   Ports                               Handshake
//   -------   ---------------------------------   -------------------------------
//   request   push, full, req_data                beat taken when push && !full
//   response  empty, pop, rsp_data                beat taken when pop && !empty
//   csr       csr_write_en, csr_index, csr_wdata  written when csr_write_en
//
// The back sequencer sends one output byte per cycle unless rsp is stalled.
// An item produces 1 or 2 bytes for a payload byte (2 when stuffed), plus
// 4 for a frame-start header and 2 or 3 for a frame-end trailer; at most 9.
// An item that produces nothing retires from the job queue at once.
// The front keeps taking beats while the job queue has room, and the back keeps
// its output register full while rsp is stalled. Reset is synchronous and
// restores the CSRs, clears the check, the queue and the output valid flag.
`default_nettype none

module stuffed_info_frame_builder
   import sifb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   output logic                        full,
   input  wire req_type                req_data,
   output logic                        empty,
   input  wire logic                   pop,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]      csr_wdata
);

   csr_type csr_ff;
   logic    q_wr, q_rd, q_full, q_empty;
   job_type q_wr_job, q_rd_job;

   // Hold the CSRs; ignore writes past the last register.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.flag     <= FLAG_RESET;
         csr_ff.esc      <= ESC_RESET;
         csr_ff.flag_sub <= FLAG_SUB_RESET;
         csr_ff.esc_sub  <= ESC_SUB_RESET;
         csr_ff.addr     <= ADDR_RESET;
         csr_ff.ctl0     <= CTL0_RESET;
         csr_ff.ctl1     <= CTL1_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_FLAG:     csr_ff.flag     <= csr_wdata;
            REG_ESC:      csr_ff.esc      <= csr_wdata;
            REG_FLAG_SUB: csr_ff.flag_sub <= csr_wdata;
            REG_ESC_SUB:  csr_ff.esc_sub  <= csr_wdata;
            REG_ADDR:     csr_ff.addr     <= csr_wdata;
            REG_CTL0:     csr_ff.ctl0     <= csr_wdata;
            REG_CTL1:     csr_ff.ctl1     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign full = q_full;

   // Front: accept request beats and fold payload into the running check.
   sifb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .q_full   (q_full),
      .q_wr     (q_wr),
      .q_job    (q_wr_job)
   );

   // Decouple the front from the byte-rate back end.
   sifb_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_wr),
      .wr_job (q_wr_job),
      .full   (q_full),
      .rd_en  (q_rd),
      .rd_job (q_rd_job),
      .empty  (q_empty)
   );

   // Back: expand each job into header, stuffed bytes and trailer.
   sifb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_ff),
      .q_empty  (q_empty),
      .q_job    (q_rd_job),
      .q_rd     (q_rd),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/core/sifb_fifo.sv */
// Short job queue between the front and the back of the frame builder.
`default_nettype none

module sifb_fifo
   import sifb_pkg::*;
#(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   output logic         full,
   input  wire logic    rd_en,
   output job_type      rd_job,
   output logic         empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_wr, do_rd;

   assign full   = (count_ff == FULL_CNT);
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (full && !do_rd) |=> $stable(wr_ptr_ff))
      else $error("queue written while full");

endmodule

`default_nettype wire

/* rtl/core/sifb_front.sv */
// Input stage: accepts items, keeps the running payload check, builds jobs.
`default_nettype none

module sifb_front
   import sifb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire req_type req_data,
   input  wire logic    q_full,
   output logic         q_wr,
   output job_type      q_job
);

   logic [BYTE_W-1:0] check_ff, check_in;
   logic [BYTE_W-1:0] base;
   logic [BYTE_W-1:0] acc;

   assign q_wr = push && !q_full;

   always_comb begin
      // Clear at frame start before this beat's payload folds in.
      base     = req_data.frame_start ? '0 : check_ff;
      acc      = req_data.has_payload ? (base ^ req_data.payload_byte) : base;
      check_in = check_ff;
      if (q_wr) begin
         check_in = req_data.frame_end ? '0 : acc;
      end
      q_job.data        = req_data.payload_byte;
      q_job.check       = acc;
      q_job.has_payload = req_data.has_payload;
      q_job.frame_start = req_data.frame_start;
      q_job.frame_end   = req_data.frame_end;
      q_job.seq_bit     = req_data.seq_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= '0;
      end else begin
         check_ff <= check_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/sifb_back.sv */
// Output sequencer: walks each job through header, stuffed bytes and trailer.
`default_nettype none

module sifb_back
   import sifb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire csr_type csr,
   input  wire logic    q_empty,
   input  wire job_type q_job,
   output logic         q_rd,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   step_type          step_ff, step_in;
   step_type          cur_step, nxt_step;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic              head_valid, out_ready, emit;
   logic [BYTE_W-1:0] ctl;
   logic              data_stuff, chk_stuff;
   logic              data_is_flag, chk_is_flag;

   function automatic step_type first_step(input job_type j);
      if (j.frame_start) begin
         return ST_FLAG;
      end else if (j.has_payload) begin
         return ST_DATA;
      end else if (j.frame_end) begin
         return ST_CHK;
      end
      return ST_IDLE;
   endfunction

   assign head_valid   = !q_empty;
   assign out_ready    = !out_valid_ff || pop;
   assign ctl          = q_job.seq_bit ? csr.ctl1 : csr.ctl0;
   assign data_is_flag = (q_job.data == csr.flag);
   assign chk_is_flag  = (q_job.check == csr.flag);
   assign data_stuff   = data_is_flag || (q_job.data == csr.esc);
   assign chk_stuff    = chk_is_flag || (q_job.check == csr.esc);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_comb begin
      cur_step = (step_ff == ST_IDLE) ? first_step(q_job) : step_ff;
      nxt_step = ST_IDLE;
      out_in   = out_ff;
      out_in.out_last = 1'b0;
      case (cur_step)
         ST_FLAG: begin
            out_in.out_byte = csr.flag;
            nxt_step        = ST_ADDR;
         end
         ST_ADDR: begin
            out_in.out_byte = csr.addr;
            nxt_step        = ST_CTL;
         end
         ST_CTL: begin
            out_in.out_byte = ctl;
            nxt_step        = ST_HCHK;
         end
         ST_HCHK: begin
            out_in.out_byte = csr.addr ^ ctl;
            nxt_step        = q_job.has_payload ? ST_DATA :
                              (q_job.frame_end ? ST_CHK : ST_IDLE);
         end
         ST_DATA: begin
            out_in.out_byte = data_stuff ? csr.esc : q_job.data;
            nxt_step        = data_stuff ? ST_DATA_SUB :
                              (q_job.frame_end ? ST_CHK : ST_IDLE);
         end
         ST_DATA_SUB: begin
            out_in.out_byte = data_is_flag ? csr.flag_sub : csr.esc_sub;
            nxt_step        = q_job.frame_end ? ST_CHK : ST_IDLE;
         end
         ST_CHK: begin
            out_in.out_byte = chk_stuff ? csr.esc : q_job.check;
            nxt_step        = chk_stuff ? ST_CHK_SUB : ST_CLOSE;
         end
         ST_CHK_SUB: begin
            out_in.out_byte = chk_is_flag ? csr.flag_sub : csr.esc_sub;
            nxt_step        = ST_CLOSE;
         end
         ST_CLOSE: begin
            out_in.out_byte = csr.flag;
            out_in.out_last = 1'b1;
            nxt_step        = ST_IDLE;
         end
         default: begin
            out_in   = out_ff;
            nxt_step = ST_IDLE;
         end
      endcase

      emit = head_valid && out_ready && (cur_step != ST_IDLE);
      // Drop a job with no bytes at once; retire others on their final byte.
      q_rd = head_valid && ((cur_step == ST_IDLE) || (emit && (nxt_step == ST_IDLE)));

      step_in      = emit ? nxt_step : step_ff;
      out_valid_in = emit ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
      if (!emit) begin
         out_in = out_ff;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   a_step_has_job: assert property (@(posedge clock) disable iff (reset)
      (step_ff != ST_IDLE) |-> head_valid)
      else $error("sequencer busy without a queued job");

   a_close_retires: assert property (@(posedge clock) disable iff (reset)
      (emit && cur_step == ST_CLOSE) |-> q_rd)
      else $error("closing flag sent without retiring the job");

   a_last_is_flag: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.out_last) |-> (out_ff.out_byte == csr.flag))
      else $error("last beat is not the flag");

   a_hold_unpopped: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> (out_valid_ff && $stable(out_ff)))
      else $error("pending result beat lost");

endmodule

`default_nettype wire

/* tb/tb_stuffed_info_frame_builder.sv */
// Self-checking testbench for the stuffed information frame builder.
`default_nettype none

module tb_stuffed_info_frame_builder;
   import sifb_pkg::*;

   localparam int CLOCK_PERIOD    = 20;
   localparam int RESET_CYCLES    = 6;
   localparam int SETTLE_CYCLES   = 16;     // job queue of 4 plus the longest item, with margin
   localparam int PHASE_COUNT     = 8;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int SENDER_IDLE_PCT = 71;
   localparam int RECV_STALL_PCT  = 71;
   localparam int BOTH_IDLE_PCT   = 38;
   localparam int MAX_REPORTS     = 100;
   localparam int RUN_LIMIT_CYCLES = 400000;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   // One row of the directed table: either a register write or an input beat.
   // For beats, typed_count >= 0 means the expected bytes are spelled out in
   // typed_bytes (first byte in the most significant position); -1 means the
   // frame predictor supplies them.
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [BYTE_W-1:0]      csr_val;
      req_type                beat;
      int                     typed_count;
      logic [71:0]            typed_bytes;
   } stim_row_type;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   push         = 1'b0;
   req_type                req_data     = '0;
   logic                   pop          = 1'b0;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [BYTE_W-1:0]      csr_wdata    = '0;
   logic                   full;
   logic                   empty;
   rsp_type                rsp_data;

   // Predictor state: our own copy of the framing registers and running check.
   csr_type           link_regs = '{flag: FLAG_RESET, esc: ESC_RESET,
                                    flag_sub: FLAG_SUB_RESET, esc_sub: ESC_SUB_RESET,
                                    addr: ADDR_RESET, ctl0: CTL0_RESET, ctl1: CTL1_RESET};
   logic [BYTE_W-1:0] running_check = '0;

   rsp_type       step_bytes[$];      // bytes caused by the beat just accepted
   rsp_type       pending_bytes[$];   // bytes owed by the block, oldest first
   stim_row_type  directed_rows[$];
   idle_mode_type idle_mode = IDLE_NONE;
   int            fail_count = 0;
   int            beats_in   = 0;
   int            beats_out  = 0;
   int            settings_used = 1;

   stuffed_info_frame_builder dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Frame predictor
   // ---------------------------------------------------------------------------

   function automatic void emit_byte(logic [BYTE_W-1:0] value, logic last);
      rsp_type b;
      b.out_byte = value;
      b.out_last = last;
      step_bytes.push_back(b);
   endfunction

   // Flag wins when flag and escape hold the same value.
   function automatic void emit_stuffed(logic [BYTE_W-1:0] value);
      if (value == link_regs.flag) begin
         emit_byte(link_regs.esc, 1'b0);
         emit_byte(link_regs.flag_sub, 1'b0);
      end else if (value == link_regs.esc) begin
         emit_byte(link_regs.esc, 1'b0);
         emit_byte(link_regs.esc_sub, 1'b0);
      end else begin
         emit_byte(value, 1'b0);
      end
   endfunction

   // Work out every output byte one accepted beat causes, in order.
   function automatic void frame_bytes_for(req_type beat);
      logic [BYTE_W-1:0] ctl;
      step_bytes.delete();
      if (beat.frame_start) begin
         // Header goes out raw, header check included; the check restarts here.
         ctl = beat.seq_bit ? link_regs.ctl1 : link_regs.ctl0;
         running_check = '0;
         emit_byte(link_regs.flag, 1'b0);
         emit_byte(link_regs.addr, 1'b0);
         emit_byte(ctl, 1'b0);
         emit_byte(link_regs.addr ^ ctl, 1'b0);
      end
      if (beat.has_payload) begin
         running_check = running_check ^ beat.payload_byte;
         emit_stuffed(beat.payload_byte);
      end
      if (beat.frame_end) begin
         emit_stuffed(running_check);
         emit_byte(link_regs.flag, 1'b1);
         running_check = '0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic void add_item(logic [BYTE_W-1:0] data, logic has, logic start,
                                    logic stop, logic seq, int count, logic [71:0] bytes);
      stim_row_type r;
      r.is_csr             = 1'b0;
      r.csr_idx            = '0;
      r.csr_val            = '0;
      r.beat.payload_byte  = data;
      r.beat.has_payload   = has;
      r.beat.frame_start   = start;
      r.beat.frame_end     = stop;
      r.beat.seq_bit       = seq;
      r.typed_count        = count;
      r.typed_bytes        = bytes;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_csr(logic [CSR_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
      stim_row_type r;
      r.is_csr      = 1'b1;
      r.csr_idx     = idx;
      r.csr_val     = val;
      r.beat        = '0;
      r.typed_count = 0;
      r.typed_bytes = '0;
      directed_rows.push_back(r);
   endfunction

   // Write one register; mirror it in the predictor once the edge has taken it.
   // Leave csr_write_en high; the caller drops it after the last write.
   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, logic [BYTE_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         REG_FLAG:     link_regs.flag     = val;
         REG_ESC:      link_regs.esc      = val;
         REG_FLAG_SUB: link_regs.flag_sub = val;
         REG_ESC_SUB:  link_regs.esc_sub  = val;
         REG_ADDR:     link_regs.addr     = val;
         REG_CTL0:     link_regs.ctl0     = val;
         REG_CTL1:     link_regs.ctl1     = val;
         default: ;    // no register here: drop the write
      endcase
   endtask

   // Stop pushing and hold until every owed byte has come out, then idle a few
   // more cycles so beats that cause no bytes also retire.
   task automatic wait_drained(int extra_cycles);
      push <= 1'b0;
      @(posedge clock);
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (extra_cycles) @(posedge clock);
   endtask

   // Push one beat. push stays high after the accepting edge so back-to-back
   // beats need no extra assignment; it is dropped for an idle gap or a drain.
   task automatic send_item(req_type beat, int typed_count, logic [71:0] typed_bytes);
      int      gap_pct;
      int      k;
      rsp_type b;
      gap_pct = (idle_mode == IDLE_SENDER) ? SENDER_IDLE_PCT :
                (idle_mode == IDLE_BOTH)   ? BOTH_IDLE_PCT   : 0;
      while ($urandom_range(99) < gap_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (full !== 1'b0)
         @(posedge clock);
      // Beat taken at this edge: advance the predictor and queue what is owed.
      frame_bytes_for(beat);
      if (typed_count < 0) begin
         foreach (step_bytes[i])
            pending_bytes.push_back(step_bytes[i]);
      end else begin
         for (k = 0; k < typed_count; k++) begin
            b.out_byte = typed_bytes[8 * (typed_count - 1 - k) +: 8];
            b.out_last = beat.frame_end && (k == typed_count - 1);
            pending_bytes.push_back(b);
         end
      end
      beats_in++;
   endtask

   // Payload bytes lean toward the current flag and escape so stuffing fires
   // often, with the byte extremes and plain random values mixed in.
   function automatic logic [BYTE_W-1:0] pick_payload();
      case ($urandom_range(7))
         0: return link_regs.flag;
         1: return link_regs.esc;
         2: return $urandom_range(1) ? 8'h00 : 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed frames (start, body, end) with random content; some
   // frames lose their end beat, and one draw in ten is a lone noise beat.
   // Beats with no payload, start or end do nothing and are not counted.
   task automatic run_random_items(int goal);
      int      counted;
      int      body;
      int      k;
      bit      held;
      req_type beat;
      counted = 0;
      held    = 1'b0;
      while (counted < goal) begin
         if (!held && counted >= goal / 2) begin
            // Pressure: pause the sender until every owed byte has come out.
            wait_drained(0);
            held = 1'b1;
         end
         if ($urandom_range(9) == 0) begin
            beat.payload_byte = 8'($urandom);
            beat.has_payload  = 1'($urandom);
            beat.frame_start  = 1'($urandom);
            beat.frame_end    = 1'($urandom);
            beat.seq_bit      = 1'($urandom);
            send_item(beat, -1, '0);
            if (beat.has_payload || beat.frame_start || beat.frame_end)
               counted++;
         end else begin
            body = $urandom_range(5);
            for (k = 0; k <= body; k++) begin
               beat.payload_byte = pick_payload();
               beat.has_payload  = ($urandom_range(9) != 0);
               beat.frame_start  = (k == 0);
               beat.frame_end    = (k == body) && ($urandom_range(11) != 0);
               beat.seq_bit      = 1'($urandom);
               send_item(beat, -1, '0);
               if (beat.has_payload || beat.frame_start || beat.frame_end)
                  counted++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: pop at random, check each beat against the oldest owed byte
   // ---------------------------------------------------------------------------

   initial begin
      rsp_type want;
      int      stall_pct;
      forever begin
         @(posedge clock);
         if (!reset && pop && empty === 1'b0) begin
            beats_out++;
            if (pending_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %02h last %0b with nothing owed",
                                         rsp_data.out_byte, rsp_data.out_last));
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                                            rsp_data.out_byte, want.out_byte));
               if (rsp_data.out_last !== want.out_last)
                  report_mismatch($sformatf("out_last %0b, want %0b (byte %02h)",
                                            rsp_data.out_last, want.out_last,
                                            want.out_byte));
            end
         end
         stall_pct = (idle_mode == IDLE_RECEIVER) ? RECV_STALL_PCT :
                     (idle_mode == IDLE_BOTH)     ? BOTH_IDLE_PCT  : 0;
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus: directed table, then random phases over several register settings
   // ---------------------------------------------------------------------------

   initial begin
      int      phase;
      csr_type cfg;

      // Directed rows at reset values: flag 7E, escape 7D, subs 5E/5D,
      // address 03, control 00 / 40.
      add_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 6,          // empty frame
               {8'h7E, 8'h03, 8'h00, 8'h03, 8'h00, 8'h7E});
      add_item(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 7,          // one-byte frame, seq one
               {8'h7E, 8'h03, 8'h40, 8'h43, 8'hFF, 8'hFF, 8'h7E});
      add_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 5,
               {8'h7E, 8'h03, 8'h00, 8'h03, 8'h00});
      add_item(8'h7E, 1'b1, 1'b0, 1'b0, 1'b0, 2, {8'h7D, 8'h5E});   // payload is the flag
      add_item(8'h7D, 1'b1, 1'b0, 1'b0, 1'b1, 2, {8'h7D, 8'h5D});   // payload is the escape
      add_item(8'h5A, 1'b0, 1'b0, 1'b0, 1'b1, 0, '0);               // no payload: no bytes
      add_item(8'h80, 1'b1, 1'b0, 1'b1, 1'b0, -1, '0);
      add_item(8'h12, 1'b1, 1'b0, 1'b0, 1'b0, 1, {8'h12});          // outside any frame
      add_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, -1, '0);              // end with no payload
      add_item(8'h7E, 1'b1, 1'b1, 1'b1, 1'b0, -1, '0);              // check equals the flag
      add_item(8'h01, 1'b1, 1'b1, 1'b0, 1'b1, -1, '0);
      add_item(8'hAA, 1'b1, 1'b1, 1'b0, 1'b0, -1, '0);              // restart mid-frame
      add_item(8'hD4, 1'b1, 1'b0, 1'b1, 1'b1, -1, '0);              // check AA^D4 = flag
      add_item(8'h7D, 1'b1, 1'b1, 1'b1, 1'b0, -1, '0);              // check equals escape
      // Flag and escape equal, every other register but the escape substitute at an extreme.
      add_csr(REG_FLAG, 8'h00);
      add_csr(REG_ESC, 8'h00);
      add_csr(REG_FLAG_SUB, 8'hFF);
      add_csr(REG_ESC_SUB, 8'h01);
      add_csr(REG_ADDR, 8'hFF);
      add_csr(REG_CTL0, 8'hFF);
      add_csr(REG_CTL1, 8'h00);
      add_csr(REG_UNUSED, 8'h55);
      add_item(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, -1, '0);  // header check hits the flag raw
      add_item(8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, -1, '0);
      add_item(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, -1, '0);
      add_item(8'h33, 1'b0, 1'b0, 1'b0, 1'b0, 0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_drained(SETTLE_CYCLES);
            csr_put(directed_rows[i].csr_idx, directed_rows[i].csr_val);
            csr_write_en <= 1'b0;
         end else begin
            send_item(directed_rows[i].beat, directed_rows[i].typed_count,
                      directed_rows[i].typed_bytes);
         end
      end
      settings_used++;

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained(SETTLE_CYCLES);
         cfg = csr_type'({$urandom, 24'($urandom)});
         case (phase)
            0: cfg = '{flag: FLAG_RESET, esc: ESC_RESET, flag_sub: FLAG_SUB_RESET,
                       esc_sub: ESC_SUB_RESET, addr: ADDR_RESET, ctl0: CTL0_RESET,
                       ctl1: CTL1_RESET};
            1: cfg = '{default: 8'h00};
            2: cfg = '{default: 8'hFF};
            4: cfg.esc = cfg.flag;
            5: begin
               cfg.flag_sub = cfg.esc;
               cfg.esc_sub  = cfg.flag;
            end
            default: ;
         endcase
         csr_put(REG_FLAG, cfg.flag);
         csr_put(REG_ESC, cfg.esc);
         csr_put(REG_FLAG_SUB, cfg.flag_sub);
         csr_put(REG_ESC_SUB, cfg.esc_sub);
         csr_put(REG_ADDR, cfg.addr);
         csr_put(REG_CTL0, cfg.ctl0);
         csr_put(REG_CTL1, cfg.ctl1);
         csr_write_en <= 1'b0;
         settings_used++;
         // Rotate: no idling, sender gaps, receiver stalls, both.
         idle_mode = idle_mode_type'(phase % 4);
         run_random_items(ITEMS_PER_PHASE);
      end

      wait_drained(SETTLE_CYCLES);
      if (pending_bytes.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", pending_bytes.size()));

      $display("run covered %0d input beats and %0d output beats", beats_in, beats_out);
      $display("over %0d register settings and four idle patterns", settings_used);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(RUN_LIMIT_CYCLES * CLOCK_PERIOD);
      $display("watchdog expired with %0d bytes owed", pending_bytes.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/sifb_pkg.sv
rtl/core/sifb_fifo.sv
rtl/core/sifb_front.sv
rtl/core/sifb_back.sv
rtl/core/stuffed_info_frame_builder.sv
tb/tb_stuffed_info_frame_builder.sv
